// File: rtl/core/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property check that is switched off while reset is active.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// File: rtl/core/rws_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rws_pkg
// Shared types and constants of the roulette wheel selector.
// ----------------------------------------------------------------------------
package rws_pkg;

  localparam int unsigned MaxPop   = 256;
  localparam int unsigned IdxW     = $clog2(MaxPop);
  localparam int unsigned CntW     = IdxW + 1;
  localparam int unsigned SumW     = 40;
  localparam int unsigned QDepth   = 2;

  typedef enum logic [1:0] {
    OpClear = 2'd0,
    OpLoad  = 2'd1,
    OpDraw  = 2'd2,
    OpNone  = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    StOk    = 2'd0,
    StEmpty = 2'd1,
    StOver  = 2'd2,
    StRsvd  = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] fitness_value;
    logic [15:0] random_fraction;
  } in_item_t;

  typedef struct packed {
    logic [7:0] selected_index;
    logic [1:0] status;
  } out_item_t;

  // Queue entry from front to back: classified transaction.
  typedef struct packed {
    opcode_e     op;
    logic [31:0] fitness;
    logic [15:0] frac;
    logic        natural;
  } cmd_t;

endpackage

// File: rtl/core/roulette_wheel_selector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// roulette_wheel_selector
// Fitness-proportionate selection over a loaded population.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive start_i with in_i; a transaction is taken when
//   start_i is high and busy_o is low. Opcodes: clear, load, draw.
//   Result channel: res_valid_o strobes one cycle per draw with res_o;
//   the receiver cannot stall, so results are never held.
//   APB port: register 0 at address 0 is natural_mode (reset 1).
// Sequencing:
//   Back-end work: a clear completes in the idle state; a load appends to
//   the table, in inverse mode after the bit-serial reciprocal divider; a
//   draw runs a binary search over the single-read table RAM, and a draw on
//   an empty or exhausted population is answered from the idle state. Each
//   transaction waits for an idle back end; each result is registered.
//   A two-entry queue lets the front take transactions while the back works.
// Reset:
//   Clears the queue, counts and total; the table needs no clearing.
// ----------------------------------------------------------------------------
module roulette_wheel_selector (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  rws_pkg::in_item_t   in_i,
  output logic                busy_o,
  output logic                res_valid_o,
  output rws_pkg::out_item_t  res_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic                paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import rws_pkg::*;

  logic natural_q;
  logic q_valid, q_pop;
  cmd_t q_data;

  assign pready = 1'b1;
  assign prdata = {31'd0, natural_q};

  // Hold the mode register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      natural_q <= 1'b1;
    end else if (psel && penable && pwrite && !paddr) begin
      natural_q <= pwdata[0];
    end
  end

  rws_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .in_i     (in_i),
    .natural_i(natural_q),
    .busy_o   (busy_o),
    .q_valid_o(q_valid),
    .q_data_o (q_data),
    .q_pop_i  (q_pop)
  );

  rws_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_data_i   (q_data),
    .q_pop_o    (q_pop),
    .res_valid_o(res_valid_o),
    .res_o      (res_o)
  );
endmodule

// File: rtl/core/rws_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rws_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module rws_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// File: rtl/core/rws_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rws_front
// Accepts transactions, latches the mode, and queues them for the back end.
// ----------------------------------------------------------------------------
module rws_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  rws_pkg::in_item_t in_i,
  input  logic              natural_i,
  output logic              busy_o,
  output logic              q_valid_o,
  output rws_pkg::cmd_t     q_data_o,
  input  logic              q_pop_i
);
  import rws_pkg::*;

  localparam int unsigned PtrW = $clog2(QDepth);

  cmd_t            q_mem_q [QDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [PtrW:0]   cnt_q;
  logic            push;
  cmd_t            cmd;

  assign busy_o    = (cnt_q == (PtrW+1)'(QDepth));
  assign push      = start_i && !busy_o && (in_i.opcode != OpNone);
  assign q_valid_o = (cnt_q != '0);
  assign q_data_o  = q_mem_q[rd_q];

  // Classify: tag with current mode; unused codes are dropped by push.
  always_comb begin
    cmd.op      = opcode_e'(in_i.opcode);
    cmd.fitness = in_i.fitness_value;
    cmd.frac    = in_i.random_fraction;
    cmd.natural = natural_i;
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_q] <= cmd;
    end
  end

  // Advance queue pointers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= wr_q + 1'b1;
      end
      if (q_pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      cnt_q <= cnt_q + (PtrW+1)'(push) - (PtrW+1)'(q_pop_i);
    end
  end
endmodule

// File: rtl/core/rws_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rws_back
// Executes queued transactions: clear, reciprocal division, table append, search.
// ----------------------------------------------------------------------------
module rws_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  input  rws_pkg::cmd_t      q_data_i,
  output logic               q_pop_o,
  output logic               res_valid_o,
  output rws_pkg::out_item_t res_o
);
  import rws_pkg::*;

  typedef enum logic [5:0] {
    SIdle = 6'b000001,
    SDiv  = 6'b000010,
    SApp  = 6'b000100,
    SMul  = 6'b001000,
    SRd   = 6'b010000,
    SCmp  = 6'b100000
  } state_e;

  state_e          st_q, st_d;
  logic [CntW-1:0] pop_q;
  logic [CntW-1:0] draws_q;
  logic [SumW-1:0] total_q;
  // Divider: 2^32 / x, restoring, one bit a cycle.
  logic [32:0]     rem_q;
  logic [32:0]     quo_q;
  logic [31:0]     dvs_q;
  logic [5:0]      dcnt_q;
  logic [31:0]     weight_q;
  // Search state.
  logic [SumW-1:0] tgt_q;
  logic [CntW-1:0] lo_q, hi_q;
  logic [SumW-1:0] rdata;
  logic [IdxW-1:0] raddr;
  logic            we;
  logic [SumW:0]   sum_w;
  logic [SumW-1:0] sum_sat;
  logic [33:0]     rem_sh;
  logic [CntW-1:0] mid;
  logic [SumW+16:0] prod;
  logic            hit;
  logic            more;

  assign q_pop_o = (st_q == SIdle) && q_valid_i;
  assign mid     = lo_q + ((hi_q - lo_q) >> 1);
  assign raddr   = mid[IdxW-1:0];
  assign sum_w   = {1'b0, total_q} + (SumW+1)'(weight_q);
  assign sum_sat = sum_w[SumW] ? {SumW{1'b1}} : sum_w[SumW-1:0];
  assign we      = (st_q == SApp);
  assign rem_sh  = {rem_q, quo_q[32]};
  assign prod    = {1'b0, total_q} * (SumW+17)'(q_data_i.frac == '0 ? 16'd1 : q_data_i.frac)
                   + (SumW+17)'(16'hFFFF);
  // Probe outcome and whether the narrowed range still holds two members.
  assign hit     = (rdata >= tgt_q);
  assign more    = hit ? (lo_q < mid) : (mid + 1'b1 < hi_q);

  rws_ram #(.Width(SumW), .Depth(MaxPop)) u_tab (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(pop_q[IdxW-1:0]),
    .wdata_i(sum_sat),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      SIdle: if (q_valid_i) begin
        priority case (q_data_i.op)
          OpLoad:  st_d = (pop_q == CntW'(MaxPop)) ? SIdle :
                          (q_data_i.natural ? SApp : SDiv);
          OpDraw:  st_d = (pop_q == '0 || draws_q >= pop_q) ? SIdle : SMul;
          default: st_d = SIdle;
        endcase
      end
      SDiv:    st_d = (dcnt_q == '0) ? SApp : SDiv;
      SApp:    st_d = SIdle;
      SMul:    st_d = (lo_q < hi_q) ? SRd : SIdle;
      SRd:     st_d = SCmp;
      SCmp:    st_d = more ? SRd : SIdle;
      default: st_d = SIdle;
    endcase
  end

  // Sequence clears, loads and draws; the table holds cumulative sums.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= SIdle;
      pop_q       <= '0;
      draws_q     <= '0;
      total_q     <= '0;
      res_valid_o <= 1'b0;
      res_o       <= '0;
      lo_q        <= '0;
      hi_q        <= '0;
    end else begin
      st_q        <= st_d;
      res_valid_o <= 1'b0;
      unique case (st_q)
        SIdle: if (q_valid_i) begin
          priority case (q_data_i.op)
            OpClear: begin
              pop_q   <= '0;
              draws_q <= '0;
              total_q <= '0;
            end
            OpDraw: begin
              lo_q <= '0;
              hi_q <= pop_q - 1'b1;
              if (pop_q == '0) begin
                res_valid_o <= 1'b1;
                res_o       <= '{selected_index: 8'd0, status: StEmpty};
              end else if (draws_q >= pop_q) begin
                res_valid_o <= 1'b1;
                res_o       <= '{selected_index: 8'd0, status: StOver};
              end
            end
            default: ;
          endcase
        end
        SApp: begin
          total_q <= sum_sat;
          pop_q   <= pop_q + 1'b1;
        end
        SMul: if (!(lo_q < hi_q)) begin
          draws_q     <= draws_q + 1'b1;
          res_valid_o <= 1'b1;
          res_o       <= '{selected_index: 8'(lo_q), status: StOk};
        end
        SCmp: begin
          if (hit) begin
            hi_q <= mid;
          end else begin
            lo_q <= mid + 1'b1;
          end
          if (!more) begin
            draws_q     <= draws_q + 1'b1;
            res_valid_o <= 1'b1;
            res_o <= '{selected_index: 8'(hit ? lo_q : mid + 1'b1),
                       status: StOk};
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath registers: divider and target.
  always_ff @(posedge clk_i) begin
    if (st_q == SIdle && q_valid_i) begin
      rem_q    <= '0;
      quo_q    <= 33'h1_0000_0000;
      dvs_q    <= q_data_i.fitness;
      dcnt_q   <= 6'd33;
      weight_q <= q_data_i.fitness;
      tgt_q    <= prod[SumW+15:16];
    end else if (st_q == SDiv) begin
      if (dcnt_q == '0) begin
        weight_q <= (dvs_q == '0 || quo_q[32]) ? 32'hFFFF_FFFF : quo_q[31:0];
      end else if (rem_sh >= {2'b0, dvs_q}) begin
        rem_q  <= 33'(rem_sh - {2'b0, dvs_q});
        quo_q  <= {quo_q[31:0], 1'b1};
        dcnt_q <= dcnt_q - 1'b1;
      end else begin
        rem_q  <= rem_sh[32:0];
        quo_q  <= {quo_q[31:0], 1'b0};
        dcnt_q <= dcnt_q - 1'b1;
      end
    end
  end
endmodule

// File: rtl/core/rws_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rws_checker
// Port-level checks of the selector.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module rws_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               res_valid_i,
  input rws_pkg::out_item_t res_i,
  input logic               pready_i
);
  import rws_pkg::*;

  logic err_res;

  // Flag a result that carries an error status.
  assign err_res = res_valid_i && (res_i.status != StOk);

  `ASSERT_NEVER(a_status_ok, clk_i, rst_ni, res_valid_i && res_i.status == StRsvd, "bad status")
  `ASSERT_CLK(a_err_idx, clk_i, rst_ni, err_res |-> res_i.selected_index == 8'd0, "index on error")
  `ASSERT_CLK(a_ready, clk_i, rst_ni, pready_i, "pready low")
endmodule

bind roulette_wheel_selector rws_checker u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni), .res_valid_i(res_valid_o), .res_i(res_o),
  .pready_i(pready)
);
